[rtl/sktwp_pkg.sv]
// Package for the sorted key table with best or weighted pick.
// Holds field widths, action and status codes and the default table depth.
// No dependencies; compile first.
package sktwp_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned MOVE_W   = 16;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned DRAW_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FIRST_W  = 12;
    localparam int unsigned COUNT_W  = 13;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_LOAD     = 2'd0;
    localparam action_t ACT_BEST     = 2'd1;
    localparam action_t ACT_WEIGHTED = 2'd2;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_FULL   = 2'd1;
    localparam status_t STAT_NOMOVE = 2'd2;

endpackage

[rtl/sktwp_if.sv]
// Valid/ready channel interfaces for the command and result words.
// Depends on sktwp_pkg for field widths and types.
interface sktwp_cmd_if;
    logic                               valid;
    logic                               ready;
    sktwp_pkg::action_t                 action;
    logic [sktwp_pkg::KEY_W-1:0]        key;
    logic [sktwp_pkg::MOVE_W-1:0]       entry_move;
    logic [sktwp_pkg::WEIGHT_W-1:0]     entry_weight;
    logic [sktwp_pkg::DRAW_W-1:0]       random_draw;

    modport source (output valid, action, key, entry_move, entry_weight, random_draw,
                    input ready);
    modport sink   (input valid, action, key, entry_move, entry_weight, random_draw,
                    output ready);
endinterface

interface sktwp_res_if;
    logic                               valid;
    logic                               ready;
    logic [sktwp_pkg::MOVE_W-1:0]       chosen_move;
    sktwp_pkg::status_t                 status;
    logic [sktwp_pkg::FIRST_W-1:0]      first_index;
    logic [sktwp_pkg::COUNT_W-1:0]      match_count;

    modport source (output valid, chosen_move, status, first_index, match_count,
                    input ready);
    modport sink   (input valid, chosen_move, status, first_index, match_count,
                    output ready);
endinterface

[rtl/sorted_key_table_weighted_pick.sv]
// Sorted key table with best or weighted pick; one word in, one word out.
// A load, an unused code or an empty table goes straight to the result word; a query runs a
//   binary search over the filled entries and a scan of the matching run, and a weighted pick
//   adds the scaling multiply and a pick scan up to the picked entry in the run.
// One command in flight, paced by the single table read port; ready returns the cycle after
// the result loads, later while a full result register waits. Reset clears fill, sequencer, valid.
module sorted_key_table_weighted_pick #(
    parameter int unsigned TABLE_DEPTH = sktwp_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    sktwp_cmd_if.sink          cmd,
    sktwp_res_if.source        result
);

    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    // weight sum over the whole table fits in weight width plus count width
    localparam int unsigned SUM_W  = sktwp_pkg::WEIGHT_W + CNT_W;
    localparam int unsigned HI_W   = SUM_W - 16;
    localparam int unsigned MB_W   = (HI_W > 16) ? HI_W : 16;
    localparam int unsigned PROD_W = sktwp_pkg::DRAW_W + MB_W;

    // Sequencer: binary search, run scan, two-step scaling multiply, pick scan.
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SRCH_RD  = 10'b00_0000_0010,
        ST_SRCH_CMP = 10'b00_0000_0100,
        ST_SCAN_RD  = 10'b00_0000_1000,
        ST_SCAN_CMP = 10'b00_0001_0000,
        ST_MUL_LO   = 10'b00_0010_0000,
        ST_MUL_HI   = 10'b00_0100_0000,
        ST_PICK_RD  = 10'b00_1000_0000,
        ST_PICK_CMP = 10'b01_0000_0000,
        ST_FINISH   = 10'b10_0000_0000
    } state_t;

    // Table memories: one write port (load), one registered read port.
    logic [sktwp_pkg::KEY_W-1:0]    key_mem    [TABLE_DEPTH];
    logic [sktwp_pkg::MOVE_W-1:0]   move_mem   [TABLE_DEPTH];
    logic [sktwp_pkg::WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];

    logic                           mem_we;
    logic [IDX_W-1:0]               rd_addr;
    logic [sktwp_pkg::KEY_W-1:0]    key_rd_reg;
    logic [sktwp_pkg::MOVE_W-1:0]   move_rd_reg;
    logic [sktwp_pkg::WEIGHT_W-1:0] weight_rd_reg;

    // Control state
    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;

    // Working registers for the current command
    sktwp_pkg::action_t             action_reg, action_next;
    logic [sktwp_pkg::KEY_W-1:0]    key_q_reg, key_q_next;
    logic [sktwp_pkg::DRAW_W-1:0]   draw_reg, draw_next;
    logic [IDX_W-1:0]               lo_reg, lo_next;
    logic [IDX_W-1:0]               hi_reg, hi_next;
    logic [IDX_W-1:0]               first_reg, first_next;
    logic [CNT_W-1:0]               i_reg, i_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [sktwp_pkg::WEIGHT_W-1:0] best_reg, best_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [PROD_W-1:0]              acc_reg, acc_next;
    logic [SUM_W-1:0]               r_reg, r_next;
    logic [sktwp_pkg::MOVE_W-1:0]   mv_reg, mv_next;
    sktwp_pkg::status_t             status_reg, status_next;

    // Result register
    logic                           out_load;
    logic [sktwp_pkg::MOVE_W-1:0]   out_move_reg;
    sktwp_pkg::status_t             out_status_reg;
    logic [sktwp_pkg::FIRST_W-1:0]  out_first_reg;
    logic [sktwp_pkg::COUNT_W-1:0]  out_count_reg;

    // Datapath helpers
    logic [IDX_W-1:0]               mid;
    logic                           key_le;
    logic                           key_eq;
    logic [IDX_W-1:0]               srch_lo;
    logic [IDX_W-1:0]               srch_hi;
    logic [MB_W-1:0]                mul_b;
    logic [PROD_W-1:0]              prod;
    logic [PROD_W:0]                scaled;
    logic [SUM_W-1:0]               total;
    logic                           scan_done;
    logic [31:0]                    first_wide;
    logic [31:0]                    count_wide;

    assign cmd.ready = (state_reg == ST_IDLE);

    assign result.valid       = out_valid_reg;
    assign result.chosen_move = out_move_reg;
    assign result.status      = out_status_reg;
    assign result.first_index = out_first_reg;
    assign result.match_count = out_count_reg;

    // Search midpoint; lo <= hi so the difference never wraps.
    assign mid     = lo_reg + IDX_W'((hi_reg - lo_reg) >> 1);
    assign key_le  = (key_q_reg <= key_rd_reg);
    assign key_eq  = (key_q_reg == key_rd_reg);
    assign srch_lo = key_le ? lo_reg : IDX_W'(mid + 1'b1);
    assign srch_hi = key_le ? mid : hi_reg;

    assign rd_addr = (state_reg == ST_SRCH_RD) ? mid : i_reg[IDX_W-1:0];

    // Shared multiplier: low sixteen bits of the sum first, then the rest.
    // floor(d*s/2^32) = floor((floor(d*s_lo/2^16) + d*s_hi) / 2^16)
    assign mul_b  = (state_reg == ST_MUL_LO) ? MB_W'(sum_reg[15:0])
                                             : MB_W'(sum_reg[SUM_W-1:16]);
    assign prod   = PROD_W'(draw_reg) * PROD_W'(mul_b);
    assign scaled = (PROD_W+1)'(acc_reg >> 16) + (PROD_W+1)'(prod);

    assign total  = sum_reg + SUM_W'(weight_rd_reg);

    assign first_wide = 32'(first_reg);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !result.ready;
        action_next    = action_reg;
        key_q_next     = key_q_reg;
        draw_next      = draw_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        i_next         = i_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        mv_next        = mv_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        scan_done      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    action_next = cmd.action;
                    key_q_next  = cmd.key;
                    draw_next   = cmd.random_draw;
                    mv_next     = '0;
                    status_next = sktwp_pkg::STAT_OK;
                    first_next  = '0;
                    count_next  = '0;
                    best_next   = '0;
                    sum_next    = '0;
                    state_next  = ST_FINISH;
                    case (cmd.action)
                        sktwp_pkg::ACT_LOAD:
                        begin
                            if (fill_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = sktwp_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        sktwp_pkg::ACT_BEST, sktwp_pkg::ACT_WEIGHTED:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = sktwp_pkg::STAT_NOMOVE;
                            end
                            else
                            begin
                                lo_next = '0;
                                hi_next = IDX_W'(fill_reg - 1'b1);
                                i_next  = '0;
                                // a single entry needs no search
                                state_next = (fill_reg == CNT_W'(1)) ? ST_SCAN_RD
                                                                     : ST_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            // unused code: nothing changes, all-zero result
                        end
                    endcase
                end
            end

            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo == srch_hi)
                begin
                    first_next = srch_lo;
                    i_next     = CNT_W'(srch_lo);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SCAN_RD:
            begin
                if (i_reg == fill_reg)
                    scan_done = 1'b1;
                else
                    state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (key_eq)
                begin
                    count_next = count_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    sum_next   = total;
                    if (weight_rd_reg > best_reg)
                    begin
                        best_next = weight_rd_reg;
                        mv_next   = move_rd_reg;
                    end
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    scan_done = 1'b1;
                end
            end

            ST_MUL_LO:
            begin
                acc_next   = prod;
                state_next = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                r_next     = scaled[SUM_W+15:16];
                sum_next   = '0;
                i_next     = CNT_W'(first_reg);
                state_next = ST_PICK_RD;
            end

            ST_PICK_RD:
            begin
                state_next = ST_PICK_CMP;
            end

            ST_PICK_CMP:
            begin
                // the sum over the run exceeds r, so this stops inside the run
                sum_next = total;
                if (total > r_reg)
                begin
                    mv_next    = move_rd_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_PICK_RD;
                end
            end

            ST_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of the matching run: decide the outcome per mode.
        if (scan_done)
        begin
            state_next = ST_FINISH;
            if (action_reg == sktwp_pkg::ACT_BEST)
            begin
                if (best_reg == '0)
                    status_next = sktwp_pkg::STAT_NOMOVE;
            end
            else if (sum_reg == '0)
            begin
                status_next = sktwp_pkg::STAT_NOMOVE;
            end
            else
            begin
                state_next = ST_MUL_LO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[fill_reg[IDX_W-1:0]]    <= cmd.key;
            move_mem[fill_reg[IDX_W-1:0]]   <= cmd.entry_move;
            weight_mem[fill_reg[IDX_W-1:0]] <= cmd.entry_weight;
        end
        key_rd_reg    <= key_mem[rd_addr];
        move_rd_reg   <= move_mem[rd_addr];
        weight_rd_reg <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_q_reg  <= key_q_next;
        draw_reg   <= draw_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        first_reg  <= first_next;
        i_reg      <= i_next;
        count_reg  <= count_next;
        best_reg   <= best_next;
        sum_reg    <= sum_next;
        acc_reg    <= acc_next;
        r_reg      <= r_next;
        mv_reg     <= mv_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_move_reg   <= mv_reg;
            out_status_reg <= status_reg;
            // report index and count modulo the field widths
            out_first_reg  <= first_wide[sktwp_pkg::FIRST_W-1:0];
            out_count_reg  <= count_wide[sktwp_pkg::COUNT_W-1:0];
        end
    end

endmodule
